/* rtl/core/gtr_pkg.sv */
// Shared types, constants and font tables for the glyph text rasterizer.
// Depends on nothing; every other file of the block imports it.
package gtr_pkg;

    localparam int GLYPH_COUNT   = 45;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ADVANCE = 6;
    localparam int DIGIT_BASE    = 7;
    localparam int LETTER_BASE   = 19;
    localparam int MASK_WIDTH    = 10;
    localparam int COORD_WIDTH   = 12;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = 12'h7FF;

    // Register indexes on the configuration port.
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_INK   = 1'b1;

    // Character codes with a glyph of their own.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0]               char_code;
        logic                     start_string;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
    } char_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] row_y;
        logic signed [COORD_WIDTH-1:0] row_x;
        logic [MASK_WIDTH-1:0]         pixel_mask;
        logic                          last_row;
    } row_word_t;

    typedef struct packed {
        logic       known;
        logic [5:0] idx;
    } glyph_sel_t;

    // One character as the front hands it to the back.
    typedef struct packed {
        logic                          known;
        logic [5:0]                    font_index;
        logic                          scale2;
        logic signed [COORD_WIDTH-1:0] pen_x;
        logic signed [COORD_WIDTH-1:0] pen_y;
    } glyph_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Each glyph packs its seven 5-bit rows, top row in the high bits.
    localparam logic [34:0] FONT_ROM [GLYPH_COUNT] = '{
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00},
        {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08},
        {5'h00,5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00},
        {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
        {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
        {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
        {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
        {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
        {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
        {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
        {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
        {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
        {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
        {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00},
        {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
        {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
        {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
        {5'h1E,5'h09,5'h09,5'h09,5'h09,5'h09,5'h1E},
        {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
        {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
        {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
        {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
        {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
        {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
        {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
        {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
        {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
        {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
        {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
        {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
        {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
        {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
        {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
        {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
        {5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04},
        {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}
    };

    function automatic glyph_sel_t lookup_glyph(input logic [7:0] code);
        logic [7:0] c;
        glyph_sel_t sel;
        c = code;
        sel.known = 1'b1;
        sel.idx   = '0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            c = c - CASE_OFFSET;
        end
        case (c)
            CH_SPACE:  sel.idx = 6'd0;
            CH_BANG:   sel.idx = 6'd1;
            CH_DQUOTE: sel.idx = 6'd2;
            CH_QUOTE:  sel.idx = 6'd3;
            CH_COMMA:  sel.idx = 6'd4;
            CH_DASH:   sel.idx = 6'd5;
            CH_DOT:    sel.idx = 6'd6;
            CH_COLON:  sel.idx = 6'd17;
            CH_QMARK:  sel.idx = 6'd18;
            default:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    sel.idx = 6'(DIGIT_BASE) + 6'(c - CH_ZERO);
                end
                else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                begin
                    sel.idx = 6'(LETTER_BASE) + 6'(c - CH_UPPER_A);
                end
                else
                begin
                    sel.known = 1'b0;
                end
            end
        endcase
        return sel;
    endfunction

    function automatic logic [GLYPH_COLS-1:0] font_bits(input logic [5:0] idx,
                                                        input logic [2:0] row);
        logic [34:0] g;
        g = '0;
        if (idx < 6'(GLYPH_COUNT))
        begin
            g = FONT_ROM[idx];
        end
        if (row < 3'(GLYPH_ROWS))
        begin
            return g[6'(34 - 5 * int'(row)) -: GLYPH_COLS];
        end
        return '0;
    endfunction

endpackage

/* rtl/core/gtr_front.sv */
// Front end: accepts characters, keeps the pen and classifies each glyph.
// Depends on gtr_pkg; pushes one job per character into gtr_queue.
module gtr_front
    import gtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  char_word_t  char_word,
    input  logic        scale2,
    input  queue_stat_t q_stat,
    output logic        push,
    output glyph_job_t  push_job
);

    logic signed [COORD_WIDTH-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_WIDTH-1:0] pen_y_reg, pen_y_next;
    logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
    logic [COORD_WIDTH:0]          adv_sum;
    glyph_sel_t                    sel;

    assign char_ready = !q_stat.full;
    assign push       = char_valid && char_ready;

    always_comb
    begin
        cur_x = char_word.start_string ? char_word.start_x : pen_x_reg;
        cur_y = char_word.start_string ? char_word.start_y : pen_y_reg;
        sel   = lookup_glyph(char_word.char_code);
        adv_sum = {cur_x[COORD_WIDTH-1], cur_x}
                + (scale2 ? 13'(2 * GLYPH_ADVANCE) : 13'(GLYPH_ADVANCE));

        push_job.known      = sel.known;
        push_job.font_index = sel.idx;
        push_job.scale2     = scale2;
        push_job.pen_x      = cur_x;
        push_job.pen_y      = cur_y;

        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (push)
        begin
            pen_y_next = cur_y;
            // The advance is positive, so only the upper limit can be crossed.
            if (!adv_sum[COORD_WIDTH] && adv_sum[COORD_WIDTH-1])
            begin
                pen_x_next = COORD_MAX;
            end
            else
            begin
                pen_x_next = adv_sum[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

/* rtl/core/gtr_queue.sv */
// Two-entry job queue between the front and the back of the rasterizer.
// Depends on gtr_pkg for the job type and depth.
module gtr_queue
    import gtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  glyph_job_t  push_job,
    input  logic        pop,
    output glyph_job_t  head_job,
    output queue_stat_t q_stat
);

    localparam int PtrWidth = $clog2(QUEUE_DEPTH);

    glyph_job_t                entry_reg [QUEUE_DEPTH];
    logic [PtrWidth-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PtrWidth:0]         count_reg, count_next;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == (PtrWidth+1)'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/gtr_back.sv */
// Back end: walks the rows of the job at the queue head, one row word a cycle
// unless stalled; builds the clipped, scaled pixel mask. Depends on gtr_pkg.
module gtr_back
    import gtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 352,
    parameter int SCREEN_HEIGHT = 282
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  glyph_job_t  head_job,
    input  queue_stat_t q_stat,
    output logic        pop,
    output logic        row_valid,
    input  logic        row_ready,
    output row_word_t   row_word
);

    logic [3:0]              row_reg, row_next;
    logic                    row_valid_reg, row_valid_next;
    row_word_t               row_word_reg, row_word_next;
    logic                    step;
    logic                    last;
    logic [2:0]              font_row;
    logic [GLYPH_COLS-1:0]   bits;
    logic [COORD_WIDTH:0]    y;
    logic [COORD_WIDTH:0]    x;
    logic                    y_vis;
    logic [2:0]              col;
    logic                    col_used;

    assign row_valid = row_valid_reg;
    assign row_word  = row_word_reg;
    assign step      = !q_stat.empty && (!row_valid_reg || row_ready);
    assign last      = row_reg == (head_job.scale2 ? 4'(2 * GLYPH_ROWS - 1)
                                                   : 4'(GLYPH_ROWS - 1));
    assign pop       = step && last;

    always_comb
    begin
        font_row = head_job.scale2 ? row_reg[3:1] : row_reg[2:0];
        bits     = font_bits(head_job.font_index, font_row);
        y        = {head_job.pen_y[COORD_WIDTH-1], head_job.pen_y} + 13'(row_reg);
        y_vis    = !y[COORD_WIDTH] && (y[COORD_WIDTH-1:0] < 12'(SCREEN_HEIGHT));

        row_word_next.row_x    = head_job.pen_x;
        row_word_next.last_row = last;
        if (!y[COORD_WIDTH] && y[COORD_WIDTH-1])
        begin
            row_word_next.row_y = COORD_MAX;
        end
        else
        begin
            row_word_next.row_y = y[COORD_WIDTH-1:0];
        end

        x        = '0;
        col      = '0;
        col_used = 1'b0;
        for (int i = 0; i < MASK_WIDTH; i++)
        begin
            col      = head_job.scale2 ? 3'(i >> 1) : 3'(i);
            col_used = head_job.scale2 || (i < GLYPH_COLS);
            x        = {head_job.pen_x[COORD_WIDTH-1], head_job.pen_x} + 13'(i);
            row_word_next.pixel_mask[i] = head_job.known && y_vis && col_used
                                       && bits[3'(GLYPH_COLS - 1) - col]
                                       && !x[COORD_WIDTH]
                                       && (x[COORD_WIDTH-1:0] < 12'(SCREEN_WIDTH));
        end

        row_next       = row_reg;
        row_valid_next = row_valid_reg;
        if (step)
        begin
            row_next       = last ? '0 : row_reg + 1'b1;
            row_valid_next = 1'b1;
        end
        else if (row_ready)
        begin
            row_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            row_word_reg <= row_word_next;
        end
    end

endmodule

/* rtl/core/glyph_text_rasterizer_top.sv */
// Top level of the glyph text rasterizer: configuration registers and the
// front, queue and back instances. Depends on gtr_pkg and the gtr_* modules.
//
// Usage: characters enter on the char channel, one word each. A word with
// start_string set first loads the pen from start_x/start_y. Each character
// yields 7 row words at scale 1 or 14 at scale 2 on the row channel, top row
// first, last_row marking the final one; the pen x then advances 6*scale,
// saturating at 2047. Unknown codes give all-zero masks.
// With the back end idle, an accepted character is written into the queue
// and its first row word is then registered by the back end. Throughput:
// one row word per cycle while the row channel takes them, set by the single
// row walker in the back end. The front takes new characters while the back
// works, until the two-entry queue fills.
// A stall on the row channel holds the row word and stalls the back end; the
// front keeps accepting until the queue is full.
// Reset clears the pen to (0,0), scale to 1, ink color to all ones and
// empties the queue. Registers: glyph_scale at 0x0, ink_color at 0x4;
// write them only while the block is idle.
module glyph_text_rasterizer_top
    import gtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 352,
    parameter int SCREEN_HEIGHT = 282
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  char_word_t  char_word,
    output logic        row_valid,
    input  logic        row_ready,
    output row_word_t   row_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  glyph_scale_reg, glyph_scale_next;
    logic [31:0] ink_color_reg, ink_color_next;
    logic        cfg_write;
    logic        push;
    logic        pop;
    glyph_job_t  push_job;
    glyph_job_t  head_job;
    queue_stat_t q_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == CFG_INK) ? ink_color_reg : {30'b0, glyph_scale_reg};

    always_comb
    begin
        glyph_scale_next = glyph_scale_reg;
        ink_color_next   = ink_color_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                CFG_SCALE: glyph_scale_next = pwdata[1:0];
                CFG_INK:   ink_color_next   = pwdata;
                default:   glyph_scale_next = glyph_scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_scale_reg <= 2'd1;
            ink_color_reg   <= '1;
        end
        else
        begin
            glyph_scale_reg <= glyph_scale_next;
            ink_color_reg   <= ink_color_next;
        end
    end

    // Scale 0 draws as 1 and scale 3 as 2, so the high bit alone selects 2.
    gtr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .scale2     (glyph_scale_reg[1]),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    gtr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    gtr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_word  (row_word)
    );

    // A drawn row always lies on the screen, so its y is never saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_word.pixel_mask != '0
        |-> !row_word.row_y[COORD_WIDTH-1]
            && row_word.row_y[COORD_WIDTH-2:0] < 11'(SCREEN_HEIGHT))
        else $error("drawn row outside the screen height");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("job queue both full and empty");

    // The back end only pops a job on its last row word.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> row_valid && row_word.last_row)
        else $error("job popped without a last row word");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for glyph_text_rasterizer_top: drives characters,
// predicts every row word and compares the results. Depends on gtr_pkg and the RTL.
module testbench
    import gtr_pkg::*;
();

    localparam int SCREEN_W = 352;
    localparam int SCREEN_H = 282;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 160;
    localparam logic [2:0] SCALE_ADDR = {CFG_SCALE, 2'b00};
    localparam logic [2:0] INK_ADDR   = {CFG_INK, 2'b00};

    // Seven 5-pixel rows per glyph, top row in the high bits.
    localparam logic [34:0] GLYPH_ART [45] = '{
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00},
        {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08},
        {5'h00,5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00},
        {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
        {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
        {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
        {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
        {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
        {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
        {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
        {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
        {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
        {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
        {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00},
        {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
        {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
        {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
        {5'h1E,5'h09,5'h09,5'h09,5'h09,5'h09,5'h1E},
        {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
        {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
        {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
        {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
        {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
        {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
        {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
        {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
        {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
        {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
        {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
        {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
        {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
        {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
        {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
        {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
        {5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04},
        {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    char_word_t  char_word = '0;
    logic        row_valid;
    logic        row_ready = 1'b0;
    row_word_t   row_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    char_word_t  pending_chars [$];
    row_word_t   expected_rows [$];
    logic [1:0]  scale_now = 2'd1;
    logic [31:0] ink_now = 32'hFFFF_FFFF;
    int          pen_x_now = 0;
    int          pen_y_now = 0;
    bit          no_gaps = 1'b0;
    int          mismatches = 0;
    int          rows_checked = 0;
    int          holdoff_left = 0;
    bit          holdoff_used = 1'b0;
    int          quiet_cycles = 0;

    glyph_text_rasterizer_top #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_word (char_word),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_word  (row_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [11:0] clamp_coord(input int v);
        if (v > 2047)
        begin
            return 12'sd2047;
        end
        if (v < -2048)
        begin
            return -12'sd2048;
        end
        return 12'(v);
    endfunction

    // Glyph number for a character code, or -1 when the font has no glyph.
    function automatic int glyph_index(input logic [7:0] code);
        int c;
        c = int'(code);
        if (c >= "a" && c <= "z")
        begin
            c = c - ("a" - "A");
        end
        case (c)
            " ":  return 0;
            "!":  return 1;
            "\"": return 2;
            "'":  return 3;
            ",":  return 4;
            "-":  return 5;
            ".":  return 6;
            ":":  return 17;
            "?":  return 18;
            default:
            begin
                if (c >= "0" && c <= "9")
                begin
                    return 7 + c - "0";
                end
                if (c >= "A" && c <= "Z")
                begin
                    return 19 + c - "A";
                end
                return -1;
            end
        endcase
    endfunction

    // Works out the row words of one accepted character and moves the pen.
    function automatic void rasterize_char(input char_word_t w);
        int eff;
        int gidx;
        int y;
        int x;
        logic [4:0] bits;
        row_word_t row;
        eff = (scale_now < 2'd2) ? 1 : 2;
        if (w.start_string)
        begin
            pen_x_now = int'($signed(w.start_x));
            pen_y_now = int'($signed(w.start_y));
        end
        gidx = glyph_index(w.char_code);
        for (int r = 0; r < GLYPH_ROWS * eff; r++)
        begin
            y = pen_y_now + r;
            row.pixel_mask = '0;
            if (gidx >= 0 && y >= 0 && y < SCREEN_H)
            begin
                bits = 5'(GLYPH_ART[gidx] >> (5 * (6 - r / eff)));
                for (int i = 0; i < GLYPH_COLS * eff; i++)
                begin
                    x = pen_x_now + i;
                    if (bits[4 - i / eff] && x >= 0 && x < SCREEN_W)
                    begin
                        row.pixel_mask[i] = 1'b1;
                    end
                end
            end
            row.row_y = clamp_coord(y);
            row.row_x = 12'(pen_x_now);
            row.last_row = (r == GLYPH_ROWS * eff - 1);
            expected_rows.push_back(row);
        end
        pen_x_now = int'(clamp_coord(pen_x_now + GLYPH_ADVANCE * eff));
    endfunction

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (roll < 30)
        begin
            return 8'(CH_LOWER_A + $urandom_range(0, 25));
        end
        if (roll < 45)
        begin
            return 8'(CH_ZERO + $urandom_range(0, 9));
        end
        if (roll < 55)
        begin
            case ($urandom_range(0, 8))
                0: return CH_SPACE;
                1: return CH_BANG;
                2: return CH_DQUOTE;
                3: return CH_QUOTE;
                4: return CH_COMMA;
                5: return CH_DASH;
                6: return CH_DOT;
                7: return CH_COLON;
                default: return CH_QMARK;
            endcase
        end
        return 8'(CH_UPPER_A + $urandom_range(0, 25));
    endfunction

    // Mostly on screen, with weight on the clipping edges and the saturation end.
    function automatic logic signed [11:0] random_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 12'($urandom);
            1: return 12'(int'($urandom_range(0, 17)) - 14);
            2: return 12'(span - 12 + int'($urandom_range(0, 14)));
            3: return 12'(2030 + int'($urandom_range(0, 17)));
            default: return 12'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic queue_char(input logic [7:0] code, input logic start,
                              input int x, input int y);
        char_word_t w;
        w.char_code = code;
        w.start_string = start;
        w.start_x = 12'(x);
        w.start_y = 12'(y);
        pending_chars.push_back(w);
    endtask

    // Runs of characters behind a pen load, like strings of text.
    task automatic queue_random(input int count);
        char_word_t w;
        for (int n = 0; n < count; n++)
        begin
            w.char_code = pick_char();
            w.start_string = ($urandom_range(0, 99) < 30);
            w.start_x = random_coord(SCREEN_W);
            w.start_y = random_coord(SCREEN_H);
            pending_chars.push_back(w);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_chars.size() != 0 || char_valid || expected_rows.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == SCALE_ADDR)
        begin
            scale_now = data[1:0];
        end
        else if (addr == INK_ADDR)
        begin
            ink_now = data;
        end
    endtask

    task automatic run_phase(input logic [1:0] scale, input logic [31:0] ink,
                             input int count);
        wait_drained();
        reg_write(SCALE_ADDR, {30'd0, scale});
        reg_write(INK_ADDR, ink);
        @(negedge clk);
        queue_random(count);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset scale: every punctuation glyph, digit and letter ends,
        // case folding, unknown codes, clipping on all sides and saturation.
        queue_char(CH_SPACE, 1'b1, 0, 0);
        queue_char(CH_BANG, 1'b0, 0, 0);
        queue_char(CH_DQUOTE, 1'b0, 0, 0);
        queue_char(CH_QUOTE, 1'b0, 0, 0);
        queue_char(CH_COMMA, 1'b0, 0, 0);
        queue_char(CH_DASH, 1'b0, 0, 0);
        queue_char(CH_DOT, 1'b0, 0, 0);
        queue_char(CH_COLON, 1'b0, 0, 0);
        queue_char(CH_QMARK, 1'b0, 0, 0);
        queue_char(CH_ZERO, 1'b0, 0, 0);
        queue_char(CH_NINE, 1'b0, 0, 0);
        queue_char(CH_UPPER_A, 1'b1, 10, 20);
        queue_char(CH_LOWER_Z, 1'b0, 0, 0);
        queue_char(8'h00, 1'b0, 0, 0);
        queue_char(8'hFF, 1'b0, -1, -1);
        queue_char(8'h7B, 1'b0, 0, 0);
        queue_char("W", 1'b1, -3, -2);
        queue_char("M", 1'b1, 348, 278);
        queue_char("8", 1'b1, 2047, 2047);
        queue_char("B", 1'b0, 0, 0);
        queue_char("H", 1'b1, -2048, -2048);

        // Double scale with the ink at zero.
        run_phase(2'd2, 32'h0000_0000, 0);
        queue_char("Q", 1'b1, -5, -7);
        queue_char("K", 1'b1, 343, 270);
        queue_char("R", 1'b1, 2040, 2040);
        queue_char("y", 1'b0, 0, 0);

        // Out-of-range scale codes fold onto 2 and 1.
        run_phase(2'd3, 32'($urandom), 40);
        run_phase(2'd0, 32'hFFFF_FFFF, 35);
        wait_drained();
        no_gaps = 1'b1;
        run_phase(2'd1, 32'($urandom), 40);
        wait_drained();
        no_gaps = 1'b0;
        run_phase(2'd2, 32'($urandom), 30);

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Character driver: valid stays up with a fixed word until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_word <= '0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                rasterize_char(char_word);
            end
            if (!char_valid || char_ready)
            begin
                if (pending_chars.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25))
                begin
                    char_valid <= 1'b1;
                    char_word <= pending_chars.pop_front();
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // Row monitor and receiver. One long hold-off lets the queue fill up.
    always @(posedge clk or negedge rst_n)
    begin
        row_word_t want;
        if (!rst_n)
        begin
            row_ready <= 1'b0;
        end
        else
        begin
            if (row_valid && row_ready)
            begin
                rows_checked++;
                if (expected_rows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected row word: y=%0d x=%0d mask=%b last=%b",
                                 row_word.row_y, row_word.row_x,
                                 row_word.pixel_mask, row_word.last_row);
                    end
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (row_word.row_y !== want.row_y || row_word.row_x !== want.row_x ||
                        row_word.pixel_mask !== want.pixel_mask ||
                        row_word.last_row !== want.last_row)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("row mismatch: expected y=%0d x=%0d mask=%b last=%b",
                                     want.row_y, want.row_x, want.pixel_mask,
                                     want.last_row);
                            $display("              got      y=%0d x=%0d mask=%b last=%b",
                                     row_word.row_y, row_word.row_x,
                                     row_word.pixel_mask, row_word.last_row);
                        end
                    end
                end
            end
            if (!holdoff_used && rows_checked >= 500)
            begin
                holdoff_used = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                row_ready <= 1'b0;
            end
            else
            begin
                row_ready <= no_gaps || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Ends the run when no word moves on any port for too long.
    always @(posedge clk)
    begin
        if ((char_valid && char_ready) || (row_valid && row_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
